// ----- sv/yaz0_pkg.sv -----
// Shared types and constants for the Yaz0 decompressor.
`timescale 1ns / 1ps
package yaz0_pkg;

    // Output packing
    localparam int LANES    = 8;
    localparam int LANE_W   = 8;
    localparam int WORD_W   = LANES * LANE_W;
    localparam int LCNT_W   = $clog2(LANES);
    localparam int COUNT_W  = 4;
    localparam int TDATA_W  = 72;
    localparam int TUSER_W  = 2;

    // Stream format
    localparam int          DIST_W         = 12;
    localparam int          REM_W          = 9;
    localparam logic [3:0]  HDR_SIZE_FIRST = 4'd4;
    localparam logic [3:0]  HDR_SIZE_LAST  = 4'd7;
    localparam logic [3:0]  HDR_LAST       = 4'd15;
    localparam logic [REM_W-1:0] SHORT_LEN_BIAS = 9'd2;
    localparam logic [REM_W-1:0] LONG_LEN_BIAS  = 9'h12;

    // One decoded byte handed to the output packer
    typedef struct packed {
        logic              valid;
        logic [LANE_W-1:0] data;
        logic              bad;
        logic              last;
        logic              stream_end;
    } pk_byte_t;

endpackage

// ----- sv/yaz0_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module yaz0_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read with the output held while no read is issued
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/yaz0_pack.sv -----
// Output packer: gathers decoded bytes into results of up to eight bytes.
`timescale 1ns / 1ps
module yaz0_pack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  yaz0_pkg::pk_byte_t              in_byte,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_bytes [63:0], byte_count [67:64], zero [71:68]
    output logic [yaz0_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    // m_tuser: stream_end [0], bad_reference [1]
    output logic [yaz0_pkg::TUSER_W-1:0]    m_tuser
);

    import yaz0_pkg::*;

    logic [WORD_W-1:0]  acc_data_reg, acc_data_next;
    logic [LCNT_W-1:0]  acc_cnt_reg,  acc_cnt_next;
    logic               acc_bad_reg,  acc_bad_next;
    logic               out_v_reg,    out_v_next;
    logic [WORD_W-1:0]  out_data_reg, out_data_next;
    logic [COUNT_W-1:0] out_cnt_reg,  out_cnt_next;
    logic               out_last_reg, out_last_next;
    logic               out_end_reg,  out_end_next;
    logic               out_bad_reg,  out_bad_next;

    logic               take;
    logic               flush;
    logic [WORD_W-1:0]  merged;

    // Accept a byte whenever the output register can be refilled
    assign in_ready = !out_v_reg || m_tready;
    assign take     = in_byte.valid && in_ready;
    assign flush    = in_byte.last || (acc_cnt_reg == LCNT_W'(LANES - 1));
    assign merged   = acc_data_reg
                    | (WORD_W'(in_byte.data) << {acc_cnt_reg, 3'b000});

    // Accumulate lanes, move a full or final word to the output register
    always_comb
    begin
        acc_data_next = acc_data_reg;
        acc_cnt_next  = acc_cnt_reg;
        acc_bad_next  = acc_bad_reg;
        out_v_next    = out_v_reg && !m_tready;
        out_data_next = out_data_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        out_end_next  = out_end_reg;
        out_bad_next  = out_bad_reg;
        if (take)
        begin
            if (flush)
            begin
                out_v_next    = 1'b1;
                out_data_next = merged;
                out_cnt_next  = COUNT_W'({1'b0, acc_cnt_reg}) + COUNT_W'(1);
                out_last_next = in_byte.last;
                out_end_next  = in_byte.stream_end;
                out_bad_next  = acc_bad_reg || in_byte.bad;
                acc_data_next = '0;
                acc_cnt_next  = '0;
                acc_bad_next  = 1'b0;
            end
            else
            begin
                acc_data_next = merged;
                acc_cnt_next  = acc_cnt_reg + LCNT_W'(1);
                acc_bad_next  = acc_bad_reg || in_byte.bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_data_reg <= '0;
            acc_cnt_reg  <= '0;
            acc_bad_reg  <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            acc_data_reg <= acc_data_next;
            acc_cnt_reg  <= acc_cnt_next;
            acc_bad_reg  <= acc_bad_next;
            out_v_reg    <= out_v_next;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {(TDATA_W - WORD_W - COUNT_W)'(0), out_cnt_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_bad_reg, out_end_reg};

endmodule

// ----- sv/yaz0_decompressor_core.sv -----
// Yaz0 decompressor top level: stream parser, copy engine and history window.
`timescale 1ns / 1ps
// Takes a Yaz0 stream one byte per transaction on s_*, the byte in s_tdata[7:0] and
// s_tuser high on header byte 0 of a new stream, and delivers results of up to eight
// bytes on m_*. Header, code and literal bytes are taken when no run is active and
// the data stage can advance. A back-reference is copied one byte per cycle unless
// the packer stalls, through the single read port of the 4096-byte history RAM;
// input is held until its last byte is issued or cut at the stream size. A nonzero
// value written on cfg_wr_en/cfg_wr_data replaces the header size, sampled on header
// byte 15. The history needs no clearing pass after reset: reads outside the written
// part of the current stream are flagged as bad references and give zero bytes.
module yaz0_decompressor_core #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [31:0]                     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: in_byte [7:0]
    input  logic [7:0]                      s_tdata,
    // s_tuser: first [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_bytes [63:0], byte_count [67:64], zero [71:68]
    output logic [yaz0_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    // m_tuser: stream_end [0], bad_reference [1]
    output logic [yaz0_pkg::TUSER_W-1:0]    m_tuser
);

    import yaz0_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_CODE,
        PH_ITEM,
        PH_REF2,
        PH_REF3
    } phase_t;

    // Parser state
    phase_t             phase_reg,      phase_next;
    logic [3:0]         hdr_idx_reg,    hdr_idx_next;
    logic [31:0]        target_reg,     target_next;
    logic [31:0]        produced_reg,   produced_next;
    logic [AW-1:0]      wpos_reg,       wpos_next;
    logic [7:0]         code_reg,       code_next;
    logic [3:0]         bits_left_reg,  bits_left_next;
    logic [7:0]         held1_reg,      held1_next;
    logic [7:0]         held2_reg,      held2_next;
    logic [31:0]        override_reg;

    // Copy engine
    logic               run_active_reg, run_active_next;
    logic [REM_W-1:0]   rem_reg,        rem_next;
    logic [DIST_W:0]    dist_reg,       dist_next;
    logic [AW-1:0]      rd_ptr_reg,     rd_ptr_next;

    // Read-data stage ahead of the history write and the packer
    logic               s1_v_reg,       s1_v_next;
    logic               s1_lit_reg,     s1_lit_next;
    logic               s1_fwd_reg,     s1_fwd_next;
    logic               s1_bad_reg,     s1_bad_next;
    logic               s1_last_reg,    s1_last_next;
    logic               s1_end_reg,     s1_end_next;
    logic [AW-1:0]      s1_addr_reg,    s1_addr_next;
    logic [7:0]         s1_byte_reg,    s1_byte_next;
    logic [7:0]         prev_byte_reg,  prev_byte_next;

    logic               pk_ready;
    logic               s1_adv;
    logic               issue;
    logic               accept;
    logic [7:0]         ram_rdata;
    logic [7:0]         s1_data;
    logic [31:0]        prod_inc;
    logic               run_end;
    pk_byte_t           pk_in;

    // Effective parser state after a possible restart
    phase_t             eff_phase;
    logic [3:0]         eff_hdr;
    logic [31:0]        eff_target;
    logic [31:0]        eff_produced;
    logic [AW-1:0]      eff_wpos;
    logic [31:0]        hdr_target;
    logic [DIST_W:0]    new_dist;

    // Pick the next phase once a code bit is consumed
    function automatic phase_t next_phase(input logic done, input logic [3:0] bits_after);
        phase_t ph;
        if (done)
        begin
            ph = PH_IDLE;
        end
        else if (bits_after == 4'd0)
        begin
            ph = PH_CODE;
        end
        else
        begin
            ph = PH_ITEM;
        end
        return ph;
    endfunction

    // Handshakes: hold input while a run is copied or the data stage is blocked
    assign s1_adv   = s1_v_reg && pk_ready;
    assign issue    = run_active_reg && (!s1_v_reg || pk_ready);
    assign s_tready = !run_active_reg && (!s1_v_reg || pk_ready);
    assign accept   = s_tvalid && s_tready;
    assign prod_inc = produced_reg + 32'd1;
    assign run_end  = (prod_inc == target_reg);

    assign eff_phase    = s_tuser ? PH_HEADER : phase_reg;
    assign eff_hdr      = s_tuser ? 4'd0  : hdr_idx_reg;
    assign eff_target   = s_tuser ? 32'd0 : target_reg;
    assign eff_produced = s_tuser ? 32'd0 : produced_reg;
    assign eff_wpos     = s_tuser ? '0    : wpos_reg;

    assign hdr_target = ((eff_hdr >= HDR_SIZE_FIRST) && (eff_hdr <= HDR_SIZE_LAST))
                      ? {eff_target[23:0], s_tdata} : eff_target;
    assign new_dist   = (phase_reg == PH_REF2)
                      ? ({1'b0, held1_reg[3:0], s_tdata} + (DIST_W + 1)'(1))
                      : ({1'b0, held1_reg[3:0], held2_reg} + (DIST_W + 1)'(1));

    // Parser, copy issue and data stage
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        target_next     = target_reg;
        produced_next   = produced_reg;
        wpos_next       = wpos_reg;
        code_next       = code_reg;
        bits_left_next  = bits_left_reg;
        held1_next      = held1_reg;
        held2_next      = held2_reg;
        run_active_next = run_active_reg;
        rem_next        = rem_reg;
        dist_next       = dist_reg;
        rd_ptr_next     = rd_ptr_reg;
        s1_v_next       = s1_adv ? 1'b0 : s1_v_reg;
        s1_lit_next     = s1_lit_reg;
        s1_fwd_next     = s1_fwd_reg;
        s1_bad_next     = s1_bad_reg;
        s1_last_next    = s1_last_reg;
        s1_end_next     = s1_end_reg;
        s1_addr_next    = s1_addr_reg;
        s1_byte_next    = s1_byte_reg;
        prev_byte_next  = s1_adv ? s1_data : prev_byte_reg;

        if (accept)
        begin
            // Drop all progress on a start flag
            if (s_tuser)
            begin
                hdr_idx_next   = 4'd0;
                target_next    = 32'd0;
                produced_next  = 32'd0;
                wpos_next      = '0;
                code_next      = 8'd0;
                bits_left_next = 4'd0;
                held1_next     = 8'd0;
                held2_next     = 8'd0;
                phase_next     = PH_HEADER;
            end
            unique case (eff_phase)
                PH_IDLE:
                begin
                end
                PH_HEADER:
                begin
                    target_next = hdr_target;
                    if (eff_hdr == HDR_LAST)
                    begin
                        if (override_reg != 32'd0)
                        begin
                            target_next = override_reg;
                        end
                        hdr_idx_next = 4'd0;
                        phase_next   = (((override_reg != 32'd0) ? override_reg : hdr_target)
                                        == 32'd0) ? PH_IDLE : PH_CODE;
                    end
                    else
                    begin
                        hdr_idx_next = eff_hdr + 4'd1;
                    end
                end
                PH_CODE:
                begin
                    code_next      = s_tdata;
                    bits_left_next = 4'd8;
                    phase_next     = PH_ITEM;
                end
                PH_ITEM:
                begin
                    if (code_reg[7])
                    begin
                        // Literal goes straight to the data stage
                        s1_v_next      = 1'b1;
                        s1_lit_next    = 1'b1;
                        s1_fwd_next    = 1'b0;
                        s1_bad_next    = 1'b0;
                        s1_last_next   = 1'b1;
                        s1_end_next    = run_end;
                        s1_addr_next   = eff_wpos;
                        s1_byte_next   = s_tdata;
                        produced_next  = prod_inc;
                        wpos_next      = wpos_reg + AW'(1);
                        code_next      = {code_reg[6:0], 1'b0};
                        bits_left_next = bits_left_reg - 4'd1;
                        phase_next     = next_phase(run_end, bits_left_reg - 4'd1);
                    end
                    else
                    begin
                        held1_next = s_tdata;
                        phase_next = PH_REF2;
                    end
                end
                PH_REF2:
                begin
                    held2_next = s_tdata;
                    if (held1_reg[7:4] != 4'd0)
                    begin
                        run_active_next = 1'b1;
                        rem_next        = REM_W'(held1_reg[7:4]) + SHORT_LEN_BIAS;
                        dist_next       = new_dist;
                        rd_ptr_next     = AW'({1'b0, eff_wpos} - (AW + 1)'(new_dist));
                    end
                    else
                    begin
                        phase_next = PH_REF3;
                    end
                end
                PH_REF3:
                begin
                    run_active_next = 1'b1;
                    rem_next        = REM_W'(s_tdata) + LONG_LEN_BIAS;
                    dist_next       = new_dist;
                    rd_ptr_next     = AW'({1'b0, eff_wpos} - (AW + 1)'(new_dist));
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Issue one history read per cycle while a run lasts and the data stage can advance
        if (issue)
        begin
            s1_v_next     = 1'b1;
            s1_lit_next   = 1'b0;
            s1_fwd_next   = (dist_reg == (DIST_W + 1)'(1));
            s1_bad_next   = (produced_reg < 32'(dist_reg));
            s1_last_next  = run_end || (rem_reg == REM_W'(1));
            s1_end_next   = run_end;
            s1_addr_next  = wpos_reg;
            produced_next = prod_inc;
            wpos_next     = wpos_reg + AW'(1);
            rd_ptr_next   = rd_ptr_reg + AW'(1);
            rem_next      = rem_reg - REM_W'(1);
            if (run_end || (rem_reg == REM_W'(1)))
            begin
                run_active_next = 1'b0;
                code_next       = {code_reg[6:0], 1'b0};
                bits_left_next  = bits_left_reg - 4'd1;
                phase_next      = next_phase(run_end, bits_left_reg - 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hdr_idx_reg    <= 4'd0;
            target_reg     <= 32'd0;
            produced_reg   <= 32'd0;
            wpos_reg       <= '0;
            code_reg       <= 8'd0;
            bits_left_reg  <= 4'd0;
            held1_reg      <= 8'd0;
            held2_reg      <= 8'd0;
            override_reg   <= 32'd0;
            run_active_reg <= 1'b0;
            rem_reg        <= '0;
            dist_reg       <= '0;
            rd_ptr_reg     <= '0;
            s1_v_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            target_reg     <= target_next;
            produced_reg   <= produced_next;
            wpos_reg       <= wpos_next;
            code_reg       <= code_next;
            bits_left_reg  <= bits_left_next;
            held1_reg      <= held1_next;
            held2_reg      <= held2_next;
            run_active_reg <= run_active_next;
            rem_reg        <= rem_next;
            dist_reg       <= dist_next;
            rd_ptr_reg     <= rd_ptr_next;
            s1_v_reg       <= s1_v_next;
            if (cfg_wr_en)
            begin
                override_reg <= cfg_wr_data;
            end
        end
    end

    // Data stage payload
    always_ff @(posedge clk)
    begin
        s1_lit_reg    <= s1_lit_next;
        s1_fwd_reg    <= s1_fwd_next;
        s1_bad_reg    <= s1_bad_next;
        s1_last_reg   <= s1_last_next;
        s1_end_reg    <= s1_end_next;
        s1_addr_reg   <= s1_addr_next;
        s1_byte_reg   <= s1_byte_next;
        prev_byte_reg <= prev_byte_next;
    end

    // Select the byte: zero when bad, forward the previous byte at distance one
    always_comb
    begin
        if (s1_bad_reg)
        begin
            s1_data = 8'd0;
        end
        else if (s1_lit_reg)
        begin
            s1_data = s1_byte_reg;
        end
        else if (s1_fwd_reg)
        begin
            s1_data = prev_byte_reg;
        end
        else
        begin
            s1_data = ram_rdata;
        end
    end

    yaz0_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (s1_data),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign pk_in.valid      = s1_v_reg;
    assign pk_in.data       = s1_data;
    assign pk_in.bad        = s1_bad_reg;
    assign pk_in.last       = s1_last_reg;
    assign pk_in.stream_end = s1_end_reg;

    yaz0_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (pk_in),
        .in_ready (pk_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // A result that ends the stream always closes its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("stream_end without run_last");

    // A result carries between one and eight bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'd8)))
        else $error("byte_count out of range");

    // An active run always has bytes left to copy
    a_run_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> (rem_reg != '0))
        else $error("copy run active with nothing left");

    // While decoding, the output never reaches the size
    a_produced_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_CODE) || (phase_reg == PH_ITEM) || (phase_reg == PH_REF2)
         || (phase_reg == PH_REF3)) |-> (produced_reg < target_reg))
        else $error("produced count passed the size while decoding");
`endif

endmodule

// ----- bench/yaz0_decompressor_core_test.sv -----
// Self-checking bench for the Yaz0 core: directed and random streams against a decoder model.
`timescale 1ns / 1ps
module yaz0_decompressor_core_test;
    import yaz0_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 300;    // longest back-reference plus margin
    localparam int HOLD_CYCLES  = 500;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int MAX_RUN      = 273;
    localparam int HISTORY      = 4096;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_CODE,
        ST_ITEM,
        ST_REF_LO,
        ST_REF_EXT
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } in_byte_t;

    typedef struct packed {
        logic [WORD_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               stream_end;
        logic               bad;
    } out_word_t;

    // Block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [31:0]          cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic [TUSER_W-1:0]   m_tuser;

    // Stimulus and expectation stores
    in_byte_t  pending_q[$];
    out_word_t expected_q[$];

    // Decoder model state
    logic [7:0]  hist [HISTORY];
    logic [11:0] wr_pos = '0;
    logic [31:0] produced_cnt = '0;
    logic [31:0] size_target = '0;
    logic [7:0]  code_reg = '0;
    logic [3:0]  bits_rem = '0;
    dec_state_t  dec_state = ST_IDLE;
    logic [3:0]  hdr_idx = '0;
    logic [7:0]  ref_hi = '0;
    logic [7:0]  ref_lo = '0;
    logic [31:0] override_q = '0;
    logic [7:0]  run_data [MAX_RUN];
    logic        run_flag [MAX_RUN];
    int unsigned run_n;

    // Flow control
    logic sender_steady = 1'b0;
    logic sink_steady = 1'b0;
    int   hold_requests = 0;
    int   holds_served;
    int   hold_left;
    int   burst_left;
    int   gap_left;
    logic [15:0] stall_pattern = 16'hFFFF;
    int   pattern_age;

    // Bookkeeping
    int   items_queued;
    int   items_accepted;
    int   item_budget;
    bit   budget_hit;
    int   junk_items;
    int   streams_built;
    int   results_seen;
    int   bad_seen;
    int   ends_seen;
    int   fail_count;
    out_word_t got;
    out_word_t want;

    yaz0_decompressor_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // Clock
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("yaz0_decompressor_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Stage one output byte and record it in the window
    task automatic stage_byte(input logic [7:0] value, input logic flag);
        run_data[run_n[8:0]] = value;
        run_flag[run_n[8:0]] = flag;
        run_n++;
        hist[wr_pos] = value;
        wr_pos = wr_pos + 12'd1;
        produced_cnt = produced_cnt + 32'd1;
    endtask

    // Copy a back-reference, cut at the stream size
    task automatic copy_back(input int unsigned len, input logic [12:0] back_dist);
        logic [11:0] src;
        while (run_n < len && produced_cnt < size_target)
        begin
            src = wr_pos - back_dist[11:0];
            if (produced_cnt < 32'(back_dist))
                stage_byte(8'h00, 1'b1);
            else
                stage_byte(hist[src], 1'b0);
        end
    endtask

    // Advance to the next code bit or go idle at the size
    task automatic close_item();
        code_reg = code_reg << 1;
        bits_rem = bits_rem - 4'd1;
        if (produced_cnt >= size_target)
            dec_state = ST_IDLE;
        else if (bits_rem == 0)
            dec_state = ST_CODE;
        else
            dec_state = ST_ITEM;
    endtask

    // Decode one compressed byte and queue the packed words it yields
    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [12:0] back_dist;
        int unsigned idx;
        int          lane;
        out_word_t   w;
        run_n = 0;
        back_dist = {1'b0, ref_hi[3:0], ref_lo} + 13'd1;
        if (start)
        begin
            wr_pos = '0;
            produced_cnt = '0;
            size_target = '0;
            code_reg = '0;
            bits_rem = '0;
            hdr_idx = '0;
            ref_hi = '0;
            ref_lo = '0;
            dec_state = ST_HEADER;
        end
        case (dec_state)
            ST_HEADER:
            begin
                if (hdr_idx >= HDR_SIZE_FIRST && hdr_idx <= HDR_SIZE_LAST)
                    size_target = {size_target[23:0], b};
                if (hdr_idx == HDR_LAST)
                begin
                    if (override_q != 0)
                        size_target = override_q;
                    hdr_idx = '0;
                    dec_state = (size_target == 0) ? ST_IDLE : ST_CODE;
                end
                else
                begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            ST_CODE:
            begin
                code_reg = b;
                bits_rem = 4'd8;
                dec_state = ST_ITEM;
            end
            ST_ITEM:
            begin
                if (code_reg[7])
                begin
                    stage_byte(b, 1'b0);
                    close_item();
                end
                else
                begin
                    ref_hi = b;
                    dec_state = ST_REF_LO;
                end
            end
            ST_REF_LO:
            begin
                ref_lo = b;
                back_dist = {1'b0, ref_hi[3:0], ref_lo} + 13'd1;
                if (ref_hi[7:4] != 0)
                begin
                    copy_back(32'(ref_hi[7:4] + SHORT_LEN_BIAS), back_dist);
                    close_item();
                end
                else
                begin
                    dec_state = ST_REF_EXT;
                end
            end
            ST_REF_EXT:
            begin
                copy_back(32'(b + LONG_LEN_BIAS), back_dist);
                close_item();
            end
            default:
            begin
            end
        endcase

        // Pack staged bytes eight to a word
        idx = 0;
        while (idx < run_n)
        begin
            w = '0;
            lane = 0;
            while (lane < LANES && idx < run_n)
            begin
                w.data[8*lane +: 8] = run_data[idx[8:0]];
                w.bad = w.bad | run_flag[idx[8:0]];
                lane++;
                idx++;
            end
            w.count = COUNT_W'(lane);
            w.last = (idx == run_n);
            w.stream_end = w.last && (produced_cnt >= size_target);
            expected_q.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts with random gaps, model updated on each transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tuser);
                void'(pending_q.pop_front());
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sender_steady)
                    gap_left = 0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q[0].data;
                    s_tuser  <= pending_q[0].start;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each transaction, stall on a rotating pattern
    // ------------------------------------------------------------------
    function automatic void note_failure(input string what, input out_word_t seen,
                                         input out_word_t ideal);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $display("%0t %s: got data=%h cnt=%0d last=%b end=%b bad=%b",
                     $realtime, what, seen.data, seen.count, seen.last, seen.stream_end,
                     seen.bad);
            $display("    want data=%h cnt=%0d last=%b end=%b bad=%b",
                     ideal.data, ideal.count, ideal.last, ideal.stream_end, ideal.bad);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.data       = m_tdata[WORD_W-1:0];
                got.count      = m_tdata[WORD_W +: COUNT_W];
                got.last       = m_tlast;
                got.stream_end = m_tuser[0];
                got.bad        = m_tuser[1];
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    note_failure("unexpected result", got, '0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad_seen += want.bad;
                    ends_seen += want.stream_end;
                    if (got !== want)
                        note_failure("result mismatch", got, want);
                end
            end

            // Start a long hold-off when one is requested
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end

            // Reload the stall pattern now and then
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'($urandom_range(0, 65535));
                    default: stall_pattern = 16'($urandom_range(0, 65535))
                                           | 16'($urandom_range(0, 65535));
                endcase
                if (stall_pattern == 0)
                    stall_pattern = 16'h0001;
            end
            pattern_age = (pattern_age + 1) % 32;

            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_steady)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= stall_pattern[0];
            end
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put_item(input logic [7:0] value, input logic start);
        if (item_budget > 0)
        begin
            pending_q.push_back('{data: value, start: start});
            items_queued++;
            item_budget--;
        end
        else
        begin
            budget_hit = 1'b1;
        end
    endtask

    // Header with the size big-endian in bytes 4 to 7
    task automatic put_header(input logic [31:0] size_field);
        int k;
        streams_built++;
        for (k = 0; k < 16; k++)
        begin
            if (k >= HDR_SIZE_FIRST && k <= HDR_SIZE_LAST)
                put_item(size_field[8*(7-k) +: 8], 1'b0);
            else
                put_item(8'($urandom_range(0, 255)), k == 0);
        end
    endtask

    // Well-formed stream with random content, cut short when the budget runs out
    task automatic gen_stream(input logic [31:0] size_field, input int cap,
                              input int long_pct, input int far_pct, input int big_pct,
                              output bit complete);
        logic [31:0] eff;
        int unsigned made;
        logic [7:0]  code;
        int          bit_i;
        logic [12:0] back_dist;
        logic [11:0] dist_m1;
        logic [3:0]  nib;
        logic [7:0]  ext;
        item_budget = cap;
        budget_hit = 1'b0;
        eff = (override_q != 0) ? override_q : size_field;
        made = 0;
        put_header(size_field);
        while (item_budget > 0 && made < eff)
        begin
            code = 8'($urandom_range(0, 255));
            put_item(code, 1'b0);
            for (bit_i = 7; bit_i >= 0 && item_budget > 0 && made < eff; bit_i--)
            begin
                if (code[bit_i])
                begin
                    put_item(8'($urandom_range(0, 255)), 1'b0);
                    made++;
                end
                else
                begin
                    if (made == 0 || $urandom_range(0, 99) < far_pct)
                        back_dist = 13'($urandom_range(1, HISTORY));
                    else
                        back_dist = 13'($urandom_range(1, (made < HISTORY) ? made : HISTORY));
                    dist_m1 = 12'(back_dist - 13'd1);
                    ext = '0;
                    if ($urandom_range(0, 99) < long_pct)
                    begin
                        nib = 4'd0;
                        ext = ($urandom_range(0, 99) < big_pct) ? 8'($urandom_range(200, 255))
                                                               : 8'($urandom_range(0, 40));
                        made += 32'(ext + LONG_LEN_BIAS);
                    end
                    else
                    begin
                        nib = 4'($urandom_range(1, 15));
                        made += 32'(nib + SHORT_LEN_BIAS);
                    end
                    put_item({nib, dist_m1[11:8]}, 1'b0);
                    put_item(dist_m1[7:0], 1'b0);
                    if (nib == 0)
                        put_item(ext, 1'b0);
                end
            end
        end
        complete = (made >= eff) && !budget_hit;
    endtask

    task automatic wait_sent();
        while (items_accepted != items_queued)
            @(posedge clk);
    endtask

    // Wait for every expected word, then let any run in progress settle
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [31:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        override_q = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  random_start;
        int  phase_no;
        int  pick;
        int  n_streams;
        bit  broken;
        bit  complete;
        logic [31:0] size_field;

        foreach (hist[i])
            hist[i] = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_write(32'd0);

        // Directed: zero size, then a byte that an idle decoder drops
        item_budget = 1000;
        put_header(32'd0);
        put_item(8'h80, 1'b0);

        // Directed: literal extremes, longest short run, far reference before
        // the start, longest extended run cut at the size, then a dropped byte
        put_header(32'd100);
        put_item(8'hC0, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'hFF, 1'b0);
        put_item(8'hF0, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'h0F, 1'b0);
        put_item(8'hFF, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'hFF, 1'b0);
        put_item(8'h12, 1'b0);

        // Directed: reference before any output, restart mid-stream and mid-header
        put_header(32'd16);
        put_item(8'h7F, 1'b0);
        put_item(8'h10, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'hA5, 1'b0);
        put_item(8'h5A, 1'b0);
        item_budget = 5;
        put_header(32'd50);
        item_budget = 1000;
        put_header(32'd3);
        put_item(8'h80, 1'b0);
        put_item(8'h3C, 1'b0);
        put_item(8'h20, 1'b0);
        put_item(8'h00, 1'b0);

        // Directed: largest header size, left open
        put_header(32'hFFFF_FFFF);
        put_item(8'hFF, 1'b0);
        put_item(8'h01, 1'b0);
        put_item(8'hFE, 1'b0);

        // Override at its smallest: every stream ends on its first byte
        cfg_write(32'd1);
        repeat (3) gen_stream($urandom, 40, 30, 20, 20, complete);

        // Override at its largest: streams only end by restart
        cfg_write(32'hFFFF_FFFF);
        repeat (2) gen_stream(32'd0, 30, 30, 10, 30, complete);

        cfg_write(32'd0);

        // Random streams
        random_start = items_queued;
        phase_no = 0;
        while (items_queued - random_start - junk_items < RANDOM_ITEMS)
        begin
            phase_no++;
            if (phase_no % 3 == 0)
            begin
                pick = $urandom_range(0, 3);
                cfg_write((pick < 2) ? 32'd0 :
                          (pick == 2) ? $urandom_range(1, 24) : $urandom_range(25, 400));
            end
            @(posedge clk);
            sender_steady <= ($urandom_range(0, 4) == 0);
            sink_steady   <= ($urandom_range(0, 4) == 0);
            if (phase_no == 1)
            begin
                // Long runs in a stream well past the window size
                gen_stream(32'd5000, 120, 100, 0, 100, complete);
            end
            else
            begin
                if (phase_no == 2)
                    hold_requests <= hold_requests + 1;
                n_streams = $urandom_range(1, 3);
                repeat (n_streams)
                begin
                    broken = ($urandom_range(0, 7) == 0);
                    pick = $urandom_range(0, 19);
                    size_field = (pick == 0) ? 32'd0 :
                                 (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 250);
                    gen_stream(size_field, broken ? $urandom_range(1, 40) : 120,
                               25, 10, 20, complete);
                    if (complete)
                    begin
                        item_budget = 3;
                        pick = $urandom_range(0, 2);
                        repeat (pick) put_item(8'($urandom_range(0, 255)), 1'b0);
                        junk_items += pick;
                    end
                end
            end
            wait_sent();
        end

        cfg_write(32'd0);
        wait_drained();

        $display("Run covered %0d streams, %0d input transactions and %0d output words",
                 streams_built, items_accepted, results_seen);
        $display("  including %0d words with bad references and %0d stream ends",
                 bad_seen, ends_seen);
        if (fail_count == 0)
            $display("yaz0_decompressor_core verification clean");
        else
            $display("yaz0_decompressor_core verification failed");
        $finish;
    end

endmodule

// ----- yaz0_decompressor_core.f -----
sv/yaz0_pkg.sv
sv/yaz0_ram.sv
sv/yaz0_pack.sv
sv/yaz0_decompressor_core.sv
bench/yaz0_decompressor_core_test.sv
